FILE: rtl/ols_pkg.sv
package ols_pkg;

    // Default number of cells in the chain.
    localparam int DEPTH_DEF = 64;

    // Widths fixed by the word format.
    localparam int REQ_W   = 3;
    localparam int POS_IN_W = 7;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_OUT_W = 7;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INS_POS   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REM_FRONT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REM_BACK  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SEARCH    = 3'd5;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_POS   = 2'd3;

    // Command broadcast to every cell of the chain for one accepted word.
    typedef struct packed {
        logic take;       // a word is accepted this cycle
        logic ins;        // open a gap at the insert position and load the value
        logic rem_front;  // every cell takes its right neighbor
        logic rem_back;   // occupancy shifts down by one
        logic search;     // compare the value against every occupied cell
    } cell_ctl_t;

endpackage

FILE: rtl/ols_cell.sv
module ols_cell #(
    parameter int PW    = 7,
    parameter int INDEX = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ols_pkg::cell_ctl_t        ctl,
    input  logic [PW-1:0]             ins_pos,
    input  logic [ols_pkg::VAL_W-1:0] value,
    input  logic [ols_pkg::VAL_W-1:0] left_data,
    input  logic                      left_occ,
    input  logic [ols_pkg::VAL_W-1:0] right_data,
    input  logic                      right_occ,
    output logic [ols_pkg::VAL_W-1:0] data,
    output logic                      occ,
    output logic                      match
);

    logic [ols_pkg::VAL_W-1:0] data_reg;
    logic [ols_pkg::VAL_W-1:0] data_next;
    logic                      occ_reg;
    logic                      occ_next;
    logic                      match_reg;
    logic                      match_next;
    logic                      at_pos;
    logic                      past_pos;

    // Where this cell sits relative to the insert position.
    assign at_pos   = (ins_pos == PW'(INDEX));
    assign past_pos = (PW'(INDEX) > ins_pos);

    // Local shift: take the new value, the left neighbor or the right neighbor.
    always_comb
    begin
        data_next = data_reg;
        occ_next  = occ_reg;
        if (ctl.ins) begin
            if (at_pos) begin
                data_next = value;
                occ_next  = 1'b1;
            end
            else if (past_pos) begin
                data_next = left_data;
                occ_next  = left_occ;
            end
        end
        else if (ctl.rem_front) begin
            data_next = right_data;
            occ_next  = right_occ;
        end
        else if (ctl.rem_back) begin
            occ_next = right_occ;
        end
    end

    // The compare sees the contents before this word's update.
    always_comb
    begin
        match_next = match_reg;
        if (ctl.take) begin
            match_next = ctl.search && occ_reg && (data_reg == value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            occ_reg   <= 1'b0;
            match_reg <= 1'b0;
        end
        else begin
            occ_reg   <= occ_next;
            match_reg <= match_next;
        end
    end

    // Element storage needs no reset; unoccupied cells are never reported.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign occ   = occ_reg;
    assign match = match_reg;

endmodule

FILE: rtl/ordered_list_store_top.sv
// Channel  Direction  Handshake            Fields
// in       input      in_valid / in_stall   req_type, position, value
// out      output     out_valid / out_stall status, found, count
//
// One word is accepted per cycle when not stalled; its result passes both stages.
// The chain of cells updates at the accept edge, and the search compares
// register in every cell, then the OR over the cells is registered at the output.
// Reset clears the element count, every cell's occupied bit and both stages.
// A stalled output holds its word; the input stalls only while both stages are full.
module ordered_list_store_top #(
    parameter int DEPTH = ols_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ols_pkg::REQ_W-1:0]     req_type,
    input  logic [ols_pkg::POS_IN_W-1:0]  position,
    input  logic signed [ols_pkg::VAL_W-1:0] value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ols_pkg::STAT_W-1:0]    status,
    output logic                          found,
    output logic [ols_pkg::CNT_OUT_W-1:0] count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > ols_pkg::POS_IN_W) ? CW : ols_pkg::POS_IN_W;

    logic [CW-1:0]                  cnt_reg;
    logic [CW-1:0]                  cnt_next;
    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    logic [ols_pkg::STAT_W-1:0]     s1_status_reg;
    logic [ols_pkg::STAT_W-1:0]     s1_status_next;
    logic [ols_pkg::CNT_OUT_W-1:0]  s1_count_reg;
    logic [ols_pkg::CNT_OUT_W-1:0]  s1_count_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [ols_pkg::STAT_W-1:0]     status_reg;
    logic [ols_pkg::STAT_W-1:0]     status_next;
    logic                           found_reg;
    logic                           found_next;
    logic [ols_pkg::CNT_OUT_W-1:0]  count_reg;
    logic [ols_pkg::CNT_OUT_W-1:0]  count_next;

    logic                           s1_free;
    logic                           s2_free;
    logic                           accept;
    logic                           full;
    logic                           empty;
    logic [PW-1:0]                  cnt_ext;
    logic [PW-1:0]                  pos_ext;
    logic [PW-1:0]                  ins_pos;
    logic [ols_pkg::STAT_W-1:0]     req_status;
    ols_pkg::cell_ctl_t             ctl;

    logic [ols_pkg::VAL_W-1:0]      cell_data [DEPTH];
    logic [DEPTH-1:0]               cell_occ;
    logic [DEPTH-1:0]               cell_match;

    // Pipeline flow control.
    assign s2_free  = !out_valid_reg || !out_stall;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_stall = !s1_free;
    assign accept   = in_valid && s1_free;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign cnt_ext = PW'(cnt_reg);
    assign pos_ext = PW'(position);

    // Request decode: status, the cell command and the new element count.
    always_comb
    begin
        req_status    = ols_pkg::ST_OK;
        ins_pos       = '0;
        ctl           = '0;
        ctl.take      = accept;
        cnt_next      = cnt_reg;
        case (req_type)
            ols_pkg::REQ_INS_FRONT:
            begin
                if (full) begin
                    req_status = ols_pkg::ST_FULL;
                end
                else begin
                    ctl.ins = accept;
                end
            end
            ols_pkg::REQ_INS_BACK:
            begin
                ins_pos = cnt_ext;
                if (full) begin
                    req_status = ols_pkg::ST_FULL;
                end
                else begin
                    ctl.ins = accept;
                end
            end
            ols_pkg::REQ_INS_POS:
            begin
                ins_pos = pos_ext;
                if (full) begin
                    req_status = ols_pkg::ST_FULL;
                end
                else if (pos_ext > cnt_ext) begin
                    req_status = ols_pkg::ST_POS;
                end
                else begin
                    ctl.ins = accept;
                end
            end
            ols_pkg::REQ_REM_FRONT:
            begin
                if (empty) begin
                    req_status = ols_pkg::ST_EMPTY;
                end
                else begin
                    ctl.rem_front = accept;
                end
            end
            ols_pkg::REQ_REM_BACK:
            begin
                if (empty) begin
                    req_status = ols_pkg::ST_EMPTY;
                end
                else begin
                    ctl.rem_back = accept;
                end
            end
            ols_pkg::REQ_SEARCH:
            begin
                ctl.search = accept;
            end
            default:
            begin
                req_status = ols_pkg::ST_OK;
            end
        endcase
        if (ctl.ins) begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (ctl.rem_front || ctl.rem_back) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    // First stage holds status and count while the cells form their compares.
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_status_next = s1_status_reg;
        s1_count_next  = s1_count_reg;
        if (s1_free) begin
            s1_valid_next  = accept;
            s1_status_next = req_status;
            s1_count_next  = ols_pkg::CNT_OUT_W'(cnt_next);
        end
    end

    // Output stage gathers the match bits of all cells.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        count_next     = count_reg;
        if (s2_free) begin
            out_valid_next = s1_valid_reg;
            status_next    = s1_status_reg;
            found_next     = |cell_match;
            count_next     = s1_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            cnt_reg       <= cnt_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_status_reg <= s1_status_next;
        s1_count_reg  <= s1_count_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        count_reg     <= count_next;
    end

    // The chain of cells; the ends see an empty neighbor.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [ols_pkg::VAL_W-1:0] l_data;
        logic                      l_occ;
        logic [ols_pkg::VAL_W-1:0] r_data;
        logic                      r_occ;

        if (i == 0) begin : g_first
            assign l_data = '0;
            assign l_occ  = 1'b0;
        end
        else begin : g_mid_l
            assign l_data = cell_data[i-1];
            assign l_occ  = cell_occ[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign r_data = '0;
            assign r_occ  = 1'b0;
        end
        else begin : g_mid_r
            assign r_data = cell_data[i+1];
            assign r_occ  = cell_occ[i+1];
        end

        ols_cell #(
            .PW    (PW),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .ins_pos    (ins_pos),
            .value      (value),
            .left_data  (l_data),
            .left_occ   (l_occ),
            .right_data (r_data),
            .right_occ  (r_occ),
            .data       (cell_data[i]),
            .occ        (cell_occ[i]),
            .match      (cell_match[i])
        );
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign count     = count_reg;

endmodule
